// ===== rtl/tlec_pkg.sv =====
`default_nettype none
package tlec_pkg;

  localparam int ADDR_W = 48;
  localparam int PADDR_W = 5;

  localparam logic [2:0] REG_OFFSET_BITS = 3'd0;
  localparam logic [2:0] REG_L1_SET_BITS = 3'd1;
  localparam logic [2:0] REG_L1_WAYS     = 3'd2;
  localparam logic [2:0] REG_L1_POLICY   = 3'd3;
  localparam logic [2:0] REG_L2_SET_BITS = 3'd4;
  localparam logic [2:0] REG_L2_WAYS     = 3'd5;

  typedef struct packed {
    logic [3:0] offset_bits;
    logic [2:0] l1_set_bits;
    logic [3:0] l1_ways;
    logic       l1_policy;
    logic [3:0] l2_set_bits;
    logic [3:0] l2_ways;
  } tlec_cfg_t;

  typedef struct packed {
    logic clr;
    logic latch_in;
    logic latch_res;
    logic l1_move;
    logic l1_ins;
    logic l2_rem;
    logic l2_ins;
    logic l2_victim;
  } tlec_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic l1_hit;
    logic l2_hit;
    logic l1_evict;
  } tlec_sts_t;

  // A way count of zero acts as one; a count above the built ways saturates.
  function automatic int way_count(input logic [3:0] w, input int maxw);
    if (w == 4'd0) return 1;
    if (int'(w) > maxw) return maxw;
    return int'(w);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/two_level_exclusive_cache.sv =====
// Hit/miss model of an L1 cache with an exclusive FIFO victim L2. An access is
// taken when start is high and busy is low; its word appears for one cycle with
// done high after the READ and CMP states, or after READ, CMP, READ2 and INS2
// when the L1 fill evicts a line, which costs another read and a write of the L2
// set memory. Each level's sets are memories with one read and one write port.
// After reset the block stays busy while it clears the valid bits of each set up
// to the larger set count (256 with the default parameters). The receiver cannot
// stall: done must be sampled in the cycle it is high. Configure only while idle.
`default_nettype none
module two_level_exclusive_cache
  import tlec_pkg::*;
#(
  parameter int ADDR_BITS = 48,
  parameter int L1_SETS   = 64,
  parameter int L1_WAYS   = 8,
  parameter int L2_SETS   = 256,
  parameter int L2_WAYS   = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               op,
  input  wire logic [ADDR_W-1:0]  address,
  output logic                    done,
  output logic                    l1_hit,
  output logic                    l2_hit,
  output logic                    memory_read,
  output logic                    memory_write,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  tlec_cfg_t cfg;
  tlec_cmd_t cmd;
  tlec_sts_t sts;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_bits <= 4'd2;
      cfg.l1_set_bits <= 3'd0;
      cfg.l1_ways <= 4'd1;
      cfg.l1_policy <= 1'b0;
      cfg.l2_set_bits <= 4'd0;
      cfg.l2_ways <= 4'd1;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_OFFSET_BITS: cfg.offset_bits <= pwdata[3:0];
        REG_L1_SET_BITS: cfg.l1_set_bits <= pwdata[2:0];
        REG_L1_WAYS:     cfg.l1_ways <= pwdata[3:0];
        REG_L1_POLICY:   cfg.l1_policy <= pwdata[0];
        REG_L2_SET_BITS: cfg.l2_set_bits <= pwdata[3:0];
        REG_L2_WAYS:     cfg.l2_ways <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_OFFSET_BITS: prdata = {28'd0, cfg.offset_bits};
      REG_L1_SET_BITS: prdata = {29'd0, cfg.l1_set_bits};
      REG_L1_WAYS:     prdata = {28'd0, cfg.l1_ways};
      REG_L1_POLICY:   prdata = {31'd0, cfg.l1_policy};
      REG_L2_SET_BITS: prdata = {28'd0, cfg.l2_set_bits};
      REG_L2_WAYS:     prdata = {28'd0, cfg.l2_ways};
      default:         prdata = 32'd0;
    endcase
  end

  tlec_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd), .busy(busy), .done(done)
  );

  tlec_datapath #(
    .ADDR_BITS(ADDR_BITS), .L1_SETS(L1_SETS), .L1_WAYS(L1_WAYS),
    .L2_SETS(L2_SETS), .L2_WAYS(L2_WAYS)
  ) u_datapath (
    .clk(clk), .rst(rst), .cfg(cfg), .op(op), .address(address), .cmd(cmd), .sts(sts),
    .l1_hit(l1_hit), .l2_hit(l2_hit), .memory_read(memory_read),
    .memory_write(memory_write)
  );

endmodule
`default_nettype wire

// ===== rtl/tlec_ram.sv =====
`default_nettype none
module tlec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/tlec_ways.sv =====
`default_nettype none
module tlec_ways #(
  parameter int WAYS = 8,
  parameter int BW   = 48
) (
  input  wire logic [WAYS-1:0][BW-1:0]      row,
  input  wire logic [WAYS-1:0]              vld,
  input  wire logic [$clog2(WAYS+1)-1:0]    nways,
  input  wire logic [BW-1:0]                tag,
  input  wire logic                         clr,
  output logic                              hit,
  output logic      [WAYS-1:0][BW-1:0]      shift_row,
  output logic      [WAYS-1:0]              shift_vld,
  output logic      [WAYS-1:0][BW-1:0]      ins_row,
  output logic      [WAYS-1:0]              ins_vld,
  output logic                              evict,
  output logic      [BW-1:0]                victim
);

  localparam int CW = $clog2(WAYS + 1);

  logic [CW-1:0] hidx;
  logic [CW-1:0] kend;
  logic [CW-1:0] fidx;
  logic          ffound;

  always_comb begin
    hit = 1'b0;
    hidx = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (CW'(j) < nways && vld[j] && row[j] == tag) begin
        hit = 1'b1;
        hidx = CW'(j);
      end
    end
  end

  // The shift runs from the hit way up to the end of the valid run after it.
  always_comb begin
    kend = nways;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (CW'(j) > hidx && CW'(j) < nways && !vld[j]) kend = CW'(j);
    end
    shift_row = row;
    shift_vld = vld;
    for (int j = 0; j < WAYS - 1; j++) begin
      if (CW'(j) >= hidx && CW'(j) + CW'(1) < kend) shift_row[j] = row[j+1];
    end
    for (int j = 0; j < WAYS; j++) begin
      if (CW'(j) == kend - CW'(1)) begin
        shift_row[j] = tag;
        shift_vld[j] = !clr;
      end
    end
  end

  always_comb begin
    ffound = 1'b0;
    fidx = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (CW'(j) < nways && !vld[j]) begin
        ffound = 1'b1;
        fidx = CW'(j);
      end
    end
    ins_row = row;
    ins_vld = vld;
    evict = !ffound;
    victim = row[0];
    if (ffound) begin
      for (int j = 0; j < WAYS; j++) begin
        if (CW'(j) == fidx) begin
          ins_row[j] = tag;
          ins_vld[j] = 1'b1;
        end
      end
    end else begin
      for (int j = 0; j < WAYS - 1; j++) begin
        if (CW'(j) + CW'(1) < nways) ins_row[j] = row[j+1];
      end
      for (int j = 0; j < WAYS; j++) begin
        if (CW'(j) == nways - CW'(1)) begin
          ins_row[j] = tag;
          ins_vld[j] = 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tlec_datapath.sv =====
`default_nettype none
module tlec_datapath
  import tlec_pkg::*;
#(
  parameter int ADDR_BITS = 48,
  parameter int L1_SETS   = 64,
  parameter int L1_WAYS   = 8,
  parameter int L2_SETS   = 256,
  parameter int L2_WAYS   = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tlec_cfg_t         cfg,
  input  wire logic              op,
  input  wire logic [ADDR_W-1:0] address,
  input  wire tlec_cmd_t         cmd,
  output tlec_sts_t              sts,
  output logic                   l1_hit,
  output logic                   l2_hit,
  output logic                   memory_read,
  output logic                   memory_write
);

  localparam int BW    = ADDR_BITS;
  localparam int IN_W  = ADDR_BITS < ADDR_W ? ADDR_BITS : ADDR_W;
  localparam int S1W   = L1_SETS > 1 ? $clog2(L1_SETS) : 1;
  localparam int S2W   = L2_SETS > 1 ? $clog2(L2_SETS) : 1;
  localparam int S1MAX = $clog2(L1_SETS + 1) - 1;
  localparam int S2MAX = $clog2(L2_SETS + 1) - 1;
  localparam int C1W   = $clog2(L1_WAYS + 1);
  localparam int C2W   = $clog2(L2_WAYS + 1);
  localparam int CLR_N = L1_SETS > L2_SETS ? L1_SETS : L2_SETS;
  localparam int CLRW  = CLR_N > 1 ? $clog2(CLR_N) : 1;

  logic [S1W-1:0] mask1;
  logic [S2W-1:0] mask2;
  logic [BW-1:0]  blk_in;
  logic [C1W-1:0] n1;
  logic [C2W-1:0] n2;

  logic           op_r;
  logic [BW-1:0]  blk_r;
  logic [BW-1:0]  victim_r;
  logic [S1W-1:0] s1_r;
  logic [S2W-1:0] s2_r;
  logic [S2W-1:0] vs;
  logic [S2W-1:0] l2_set;
  logic [BW-1:0]  l2_tag;

  logic [CLRW-1:0]    clr_idx;
  logic [L1_WAYS-1:0] l1_vrd, l1_vwd;
  logic [L2_WAYS-1:0] l2_vrd, l2_vwd;
  logic [S1W-1:0]     l1_vaddr;
  logic [S2W-1:0]     l2_vaddr;
  logic               l1_vwe, l2_vwe;

  logic [L1_WAYS-1:0][BW-1:0] l1_rd, l1_shift, l1_ins, l1_wd;
  logic [L1_WAYS-1:0]         l1_shift_v, l1_ins_v, l1_wv;
  logic [L2_WAYS-1:0][BW-1:0] l2_rd, l2_shift, l2_ins, l2_wd;
  logic [L2_WAYS-1:0]         l2_shift_v, l2_ins_v, l2_wv;
  logic                       h1, h2, ev1, ev2;
  logic [BW-1:0]              vic1, vic2;
  logic                       l1_we, l2_we;

  always_comb begin
    mask1 = ~({S1W{1'b1}} << ((int'(cfg.l1_set_bits) > S1MAX) ? S1MAX
                                                              : int'(cfg.l1_set_bits)));
    mask2 = ~({S2W{1'b1}} << ((int'(cfg.l2_set_bits) > S2MAX) ? S2MAX
                                                              : int'(cfg.l2_set_bits)));
    n1 = C1W'(way_count(cfg.l1_ways, L1_WAYS));
    n2 = C2W'(way_count(cfg.l2_ways, L2_WAYS));
    blk_in = BW'(address[IN_W-1:0]) >> cfg.offset_bits;
    vs = victim_r[S2W-1:0] & mask2;
    l2_set = cmd.l2_victim ? vs : s2_r;
    l2_tag = cmd.l2_victim ? victim_r : blk_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r <= op;
      blk_r <= blk_in;
      s1_r <= blk_in[S1W-1:0] & mask1;
      s2_r <= blk_in[S2W-1:0] & mask2;
    end
    if (cmd.latch_res) begin
      victim_r <= vic1;
      l1_hit <= h1;
      l2_hit <= !h1 && h2;
      memory_read <= !h1 && !h2;
      memory_write <= op_r;
    end
  end

  tlec_ways #(.WAYS(L1_WAYS), .BW(BW)) u_l1_ways (
    .row(l1_rd), .vld(l1_vrd), .nways(n1), .tag(blk_r), .clr(1'b0),
    .hit(h1), .shift_row(l1_shift), .shift_vld(l1_shift_v),
    .ins_row(l1_ins), .ins_vld(l1_ins_v), .evict(ev1), .victim(vic1)
  );

  tlec_ways #(.WAYS(L2_WAYS), .BW(BW)) u_l2_ways (
    .row(l2_rd), .vld(l2_vrd), .nways(n2), .tag(l2_tag), .clr(1'b1),
    .hit(h2), .shift_row(l2_shift), .shift_vld(l2_shift_v),
    .ins_row(l2_ins), .ins_vld(l2_ins_v), .evict(ev2), .victim(vic2)
  );

  // The dropped oldest L2 line leaves no trace, so its victim output is unused here.
  logic unused_l2;
  assign unused_l2 = ev2 ^ (^vic2);

  always_comb begin
    l1_we = (cmd.l1_move && cfg.l1_policy) || cmd.l1_ins;
    l1_wd = cmd.l1_ins ? l1_ins : l1_shift;
    l1_wv = cmd.l1_ins ? l1_ins_v : l1_shift_v;
    l2_we = cmd.l2_rem || cmd.l2_ins;
    l2_wd = cmd.l2_ins ? l2_ins : l2_shift;
    l2_wv = cmd.l2_ins ? l2_ins_v : l2_shift_v;
    // After reset the valid memories are walked set by set and cleared.
    l1_vwe = l1_we || (cmd.clr && int'(clr_idx) < L1_SETS);
    l2_vwe = l2_we || (cmd.clr && int'(clr_idx) < L2_SETS);
    l1_vaddr = cmd.clr ? clr_idx[S1W-1:0] : s1_r;
    l2_vaddr = cmd.clr ? clr_idx[S2W-1:0] : l2_set;
    l1_vwd = cmd.clr ? '0 : l1_wv;
    l2_vwd = cmd.clr ? '0 : l2_wv;
    sts.clr_last = (int'(clr_idx) == CLR_N - 1);
    sts.l1_hit = h1;
    sts.l2_hit = h2;
    sts.l1_evict = ev1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr) begin
      clr_idx <= clr_idx + CLRW'(1);
    end
  end

  tlec_ram #(.WIDTH(L1_WAYS * BW), .DEPTH(L1_SETS)) u_l1_ram (
    .clk(clk), .we(l1_we), .waddr(s1_r), .wdata(l1_wd), .raddr(s1_r), .rdata(l1_rd)
  );

  tlec_ram #(.WIDTH(L1_WAYS), .DEPTH(L1_SETS)) u_l1_vram (
    .clk(clk), .we(l1_vwe), .waddr(l1_vaddr), .wdata(l1_vwd), .raddr(s1_r), .rdata(l1_vrd)
  );

  tlec_ram #(.WIDTH(L2_WAYS * BW), .DEPTH(L2_SETS)) u_l2_ram (
    .clk(clk), .we(l2_we), .waddr(l2_set), .wdata(l2_wd), .raddr(l2_set), .rdata(l2_rd)
  );

  tlec_ram #(.WIDTH(L2_WAYS), .DEPTH(L2_SETS)) u_l2_vram (
    .clk(clk), .we(l2_vwe), .waddr(l2_vaddr), .wdata(l2_vwd), .raddr(l2_set),
    .rdata(l2_vrd)
  );

endmodule
`default_nettype wire

// ===== rtl/tlec_ctrl.sv =====
`default_nettype none
module tlec_ctrl
  import tlec_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire tlec_sts_t sts,
  output tlec_cmd_t      cmd,
  output logic           busy,
  output logic           done
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_CMP, S_READ2, S_INS2
  } state_t;

  state_t state;

  always_comb begin
    busy = (state != S_IDLE);
    cmd.clr       = (state == S_CLEAR);
    cmd.latch_in  = (state == S_IDLE) && start;
    cmd.latch_res = (state == S_CMP);
    cmd.l1_move   = (state == S_CMP) && sts.l1_hit;
    cmd.l1_ins    = (state == S_CMP) && !sts.l1_hit;
    cmd.l2_rem    = (state == S_CMP) && !sts.l1_hit && sts.l2_hit;
    cmd.l2_ins    = (state == S_INS2);
    cmd.l2_victim = (state == S_READ2) || (state == S_INS2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: if (sts.clr_last) state <= S_IDLE;
        S_IDLE:  if (start) state <= S_READ;
        S_READ:  state <= S_CMP;
        S_CMP: begin
          if (!sts.l1_hit && sts.l1_evict) begin
            state <= S_READ2;
          end else begin
            state <= S_IDLE;
            done <= 1'b1;
          end
        end
        S_READ2: state <= S_INS2;
        S_INS2: begin
          state <= S_IDLE;
          done <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tlec_checker.sv =====
`default_nettype none
module tlec_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic l1_hit,
  input wire logic l2_hit,
  input wire logic memory_read
);

  // A word never follows the previous one in the next cycle.
  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done high in two consecutive cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted word did not make the block busy");

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    done |-> !(l1_hit && l2_hit))
    else $error("hit reported in both levels");

  a_mem_read: assert property (@(posedge clk) disable iff (rst)
    done |-> (memory_read == !(l1_hit || l2_hit)))
    else $error("memory read flag disagrees with hit flags");

endmodule

bind two_level_exclusive_cache tlec_checker u_tlec_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .l1_hit(l1_hit), .l2_hit(l2_hit), .memory_read(memory_read)
);
`default_nettype wire
